### hdl/sws_pkg.sv
// ============================================================================
// sws_pkg - shared definitions for the sliding window sigma and offset block
// ----------------------------------------------------------------------------
// Register indexes, fixed field widths and the command and status groups
// that pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package sws_pkg;

   // Fixed widths of the register and result fields.
   localparam int WL_BITS        = 6;
   localparam int WL_RESET       = 10;
   localparam int CSR_INDEX_BITS = 1;
   localparam int OUT_BITS       = 32;

   // Fraction bits carried by the results. The radicand is scaled by twice
   // the sigma fraction so that the root carries it once.
   localparam int SIGMA_FRAC_BITS  = 8;
   localparam int OFFSET_FRAC_BITS = 8;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFERENCE     = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic ring_read;
      logic square;
      logic accumulate;
      logic mul_load;
      logic mul_step;
      logic diff;
      logic start;
      logic sqrt_step;
      logic off_capture;
      logic sig_start;
      logic out_load;
   } sws_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic div_busy;
      logic out_free;
   } sws_sts_type;

endpackage

`default_nettype wire

### hdl/sws_ram.sv
// ============================================================================
// sws_ram - generic single write port, single read port memory
// ----------------------------------------------------------------------------
// One write and one read per cycle. The read data is registered.
// ============================================================================
`default_nettype none

module sws_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/sws_div.sv
// ============================================================================
// sws_div - restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
// Loads dividend and divisor on start and stays busy until every dividend
// bit has been shifted through. The quotient holds until the next start.
// ============================================================================
`default_nettype none

module sws_div #(
   parameter int DVD_W = 39,
   parameter int DVS_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  busy,
   output logic      [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic             take;

   always_comb begin
      trial     = {rem_ff, quo_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      take      = (trial >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], take};
         rem_in = take ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### hdl/sws_dp.sv
// ============================================================================
// sws_dp - datapath of the sliding window sigma and offset block
// ----------------------------------------------------------------------------
// Sample ring, running sums, bit-serial multiplies, bit-serial square root,
// the shared divider, the registers and the result register.
// ============================================================================
`default_nettype none

module sws_dp
   import sws_pkg::*;
#(
   parameter int MAX_WINDOW  = 32,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sws_cmd_type               cmd,
   output sws_sts_type                    sts,
   input  wire logic [SAMPLE_BITS-1:0]    req_sample,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [SAMPLE_BITS-1:0]    csr_wr_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [OUT_BITS-1:0]       rsp_sigma,
   output logic      [OUT_BITS-1:0]       rsp_offset
);

   localparam int NW_W   = $clog2(MAX_WINDOW + 1);
   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int SUM_W  = SAMPLE_BITS + NW_W;
   localparam int SQ1_W  = 2 * SAMPLE_BITS - 1;
   localparam int SQ_W   = SQ1_W + NW_W;
   localparam int P_W    = 2 * SUM_W;
   localparam int RAD_W  = P_W + 2 * SIGMA_FRAC_BITS;
   localparam int ROOT_W = RAD_W / 2;
   localparam int DIF_W  = SUM_W + 1;
   localparam int DIV_W  = DIF_W + OFFSET_FRAC_BITS;
   localparam int CMP_W  = (NW_W > WL_BITS) ? NW_W : WL_BITS;
   localparam int SAT_W  = (DIV_W > OUT_BITS) ? DIV_W : OUT_BITS + 1;

   // Configuration registers.
   logic        [WL_BITS-1:0]     wl_ff, wl_in;
   logic signed [SAMPLE_BITS-1:0] ref_ff, ref_in;

   // Window state.
   logic        [SLOT_W-1:0]      slot_ff, slot_in;
   logic        [NW_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic        [SQ_W-1:0]        sq_ff, sq_in;

   // Per-sample update.
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0] old_ff, old_in;
   logic        [SQ1_W-1:0]       new_sq_ff, new_sq_in;
   logic        [SQ1_W-1:0]       old_sq_ff, old_sq_in;

   // Shift-add multiplies.
   logic        [P_W-1:0]         s1_acc_ff, s1_acc_in;
   logic        [P_W-1:0]         s1_mcand_ff, s1_mcand_in;
   logic        [SUM_W-1:0]       s1_mplier_ff, s1_mplier_in;
   logic        [P_W-1:0]         ns2_acc_ff, ns2_acc_in;
   logic        [P_W-1:0]         ns2_mcand_ff, ns2_mcand_in;
   logic        [NW_W-1:0]        n_mplier_ff, n_mplier_in;
   logic signed [SUM_W-1:0]       nref_acc_ff, nref_acc_in;
   logic signed [SUM_W-1:0]       nref_mcand_ff, nref_mcand_in;

   // Differences, square root and results.
   logic        [P_W-1:0]         var_ff, var_in;
   logic signed [DIF_W-1:0]       dif_ff, dif_in;
   logic        [RAD_W-1:0]       rad_ff, rad_in;
   logic        [ROOT_W:0]        rem_ff, rem_in;
   logic        [ROOT_W-1:0]      root_ff, root_in;
   logic        [OUT_BITS-1:0]    off_ff, off_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic        [OUT_BITS-1:0]    rsp_sigma_ff, rsp_sigma_in;
   logic        [OUT_BITS-1:0]    rsp_offset_ff, rsp_offset_in;

   // Combinational helpers.
   logic        [CMP_W-1:0]       wl_ext;
   logic        [CMP_W-1:0]       n_cmp;
   logic        [NW_W-1:0]        n_c;
   logic                          full_c;
   logic        [NW_W-1:0]        slot_next;
   logic        [SAMPLE_BITS-1:0] ram_rd_data;
   logic signed [SAMPLE_BITS-1:0] old_val;
   logic signed [2*SAMPLE_BITS-1:0] prod_new;
   logic signed [2*SAMPLE_BITS-1:0] prod_old;
   logic        [SUM_W-1:0]       s1_mag;
   logic        [DIF_W-1:0]       d_mag;
   logic        [ROOT_W+2:0]      sq_trial_rem;
   logic        [ROOT_W+2:0]      sq_trial_sub;
   logic        [ROOT_W+2:0]      sq_diff;
   logic                          div_start;
   logic        [DIV_W-1:0]       div_dividend;
   logic                          div_busy;
   logic        [DIV_W-1:0]       div_quotient;

   function automatic logic [OUT_BITS-1:0] sat_out(input logic [DIV_W-1:0] q);
      logic [SAT_W-1:0] q_ext;
      q_ext = SAT_W'(q);
      if (q_ext > SAT_W'({OUT_BITS{1'b1}})) begin
         return {OUT_BITS{1'b1}};
      end
      return q_ext[OUT_BITS-1:0];
   endfunction

   // Effective window: zero means one sample, above the ring depth saturates.
   always_comb begin
      wl_ext = CMP_W'(wl_ff);
      if (wl_ff == '0) begin
         n_cmp = CMP_W'(1);
      end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
         n_cmp = CMP_W'(MAX_WINDOW);
      end else begin
         n_cmp = wl_ext;
      end
      n_c = n_cmp[NW_W-1:0];
   end

   assign full_c    = (fill_ff >= n_c);
   assign slot_next = NW_W'(slot_ff) + 1'b1;
   assign old_val   = full_c ? $signed(ram_rd_data) : '0;
   assign prod_new  = sample_ff * sample_ff;
   assign prod_old  = old_val * old_val;
   assign s1_mag    = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);
   assign d_mag     = dif_ff[DIF_W-1] ? $unsigned(-dif_ff) : $unsigned(dif_ff);

   assign sq_trial_rem = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_trial_sub = {1'b0, root_ff, 2'b01};
   assign sq_diff      = sq_trial_rem - sq_trial_sub;

   assign div_start    = cmd.start | cmd.sig_start;
   assign div_dividend = cmd.sig_start ? DIV_W'(root_ff)
                                       : {d_mag, {OFFSET_FRAC_BITS{1'b0}}};

   always_comb begin
      wl_in          = wl_ff;
      ref_in         = ref_ff;
      slot_in        = slot_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      sq_in          = sq_ff;
      sample_in      = sample_ff;
      old_in         = old_ff;
      new_sq_in      = new_sq_ff;
      old_sq_in      = old_sq_ff;
      s1_acc_in      = s1_acc_ff;
      s1_mcand_in    = s1_mcand_ff;
      s1_mplier_in   = s1_mplier_ff;
      ns2_acc_in     = ns2_acc_ff;
      ns2_mcand_in   = ns2_mcand_ff;
      n_mplier_in    = n_mplier_ff;
      nref_acc_in    = nref_acc_ff;
      nref_mcand_in  = nref_mcand_ff;
      var_in         = var_ff;
      dif_in         = dif_ff;
      rad_in         = rad_ff;
      rem_in         = rem_ff;
      root_in        = root_ff;
      off_in         = off_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_sigma_in   = rsp_sigma_ff;
      rsp_offset_in  = rsp_offset_ff;

      if (cmd.ring_read) begin
         sample_in = $signed(req_sample);
      end

      // The evicted sample only counts once the window is full.
      if (cmd.square) begin
         old_in    = old_val;
         new_sq_in = prod_new[SQ1_W-1:0];
         old_sq_in = prod_old[SQ1_W-1:0];
      end

      if (cmd.accumulate) begin
         sum_in = sum_ff + SUM_W'(sample_ff) - SUM_W'(old_ff);
         sq_in  = sq_ff + SQ_W'(new_sq_ff) - SQ_W'(old_sq_ff);
         if (!full_c) begin
            fill_in = fill_ff + 1'b1;
         end
         if (slot_next >= n_c) begin
            slot_in = '0;
         end else begin
            slot_in = slot_next[SLOT_W-1:0];
         end
      end

      if (cmd.mul_load) begin
         s1_acc_in     = '0;
         s1_mcand_in   = P_W'(s1_mag);
         s1_mplier_in  = s1_mag;
         ns2_acc_in    = '0;
         ns2_mcand_in  = P_W'(sq_ff);
         n_mplier_in   = n_c;
         nref_acc_in   = '0;
         nref_mcand_in = SUM_W'(ref_ff);
      end

      if (cmd.mul_step) begin
         if (s1_mplier_ff[0]) begin
            s1_acc_in = s1_acc_ff + s1_mcand_ff;
         end
         if (n_mplier_ff[0]) begin
            ns2_acc_in  = ns2_acc_ff + ns2_mcand_ff;
            nref_acc_in = nref_acc_ff + nref_mcand_ff;
         end
         s1_mcand_in   = s1_mcand_ff << 1;
         s1_mplier_in  = s1_mplier_ff >> 1;
         ns2_mcand_in  = ns2_mcand_ff << 1;
         nref_mcand_in = nref_mcand_ff <<< 1;
         n_mplier_in   = n_mplier_ff >> 1;
      end

      if (cmd.diff) begin
         var_in = ns2_acc_ff - s1_acc_ff;
         dif_in = DIF_W'(sum_ff) - DIF_W'(nref_acc_ff);
      end

      if (cmd.start) begin
         rad_in  = {var_ff, {(2 * SIGMA_FRAC_BITS){1'b0}}};
         rem_in  = '0;
         root_in = '0;
      end

      // One root bit per step: bring down two radicand bits, try root*4+1.
      if (cmd.sqrt_step) begin
         rad_in = rad_ff << 2;
         if (sq_trial_rem >= sq_trial_sub) begin
            rem_in  = sq_diff[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = sq_trial_rem[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end

      if (cmd.off_capture) begin
         off_in = sat_out(div_quotient);
      end

      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sigma_in  = sat_out(div_quotient);
         rsp_offset_in = off_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Writing the window length restarts filling.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               wl_in   = csr_wr_data[WL_BITS-1:0];
               slot_in = '0;
               fill_in = '0;
               sum_in  = '0;
               sq_in   = '0;
            end
            CSR_REFERENCE: begin
               ref_in = $signed(csr_wr_data[SAMPLE_BITS-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff        <= WL_BITS'(WL_RESET);
         ref_ff       <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wl_ff        <= wl_in;
         ref_ff       <= ref_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      old_ff        <= old_in;
      new_sq_ff     <= new_sq_in;
      old_sq_ff     <= old_sq_in;
      s1_acc_ff     <= s1_acc_in;
      s1_mcand_ff   <= s1_mcand_in;
      s1_mplier_ff  <= s1_mplier_in;
      ns2_acc_ff    <= ns2_acc_in;
      ns2_mcand_ff  <= ns2_mcand_in;
      n_mplier_ff   <= n_mplier_in;
      nref_acc_ff   <= nref_acc_in;
      nref_mcand_ff <= nref_mcand_in;
      var_ff        <= var_in;
      dif_ff        <= dif_in;
      rad_ff        <= rad_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      off_ff        <= off_in;
      rsp_sigma_ff  <= rsp_sigma_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   sws_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.square),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.ring_read),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   sws_div #(
      .DVD_W (DIV_W),
      .DVS_W (NW_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_c),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign sts.full     = full_c;
   assign sts.div_busy = div_busy;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sigma  = rsp_sigma_ff;
   assign rsp_offset = rsp_offset_ff;

endmodule

`default_nettype wire

### hdl/sws_ctrl.sv
// ============================================================================
// sws_ctrl - sequencer of the sliding window sigma and offset block
// ----------------------------------------------------------------------------
// Walks one sample through the window update and, in a full window, the
// multiplies, square root and two divisions, then loads the output register.
// ============================================================================
`default_nettype none

module sws_ctrl
   import sws_pkg::*;
#(
   parameter int MUL_STEPS  = 30,
   parameter int SQRT_STEPS = 38
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire sws_sts_type sts,
   output sws_cmd_type      cmd
);

   localparam int STEPS_MAX = (MUL_STEPS > SQRT_STEPS) ? MUL_STEPS : SQRT_STEPS;
   localparam int CNT_W     = $clog2(STEPS_MAX);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SQUARE   = 4'd1;
   localparam logic [3:0] ST_ACCUM    = 4'd2;
   localparam logic [3:0] ST_CHECK    = 4'd3;
   localparam logic [3:0] ST_MUL      = 4'd4;
   localparam logic [3:0] ST_DIFF     = 4'd5;
   localparam logic [3:0] ST_START    = 4'd6;
   localparam logic [3:0] ST_SQRT     = 4'd7;
   localparam logic [3:0] ST_OFF_WAIT = 4'd8;
   localparam logic [3:0] ST_SIG_WAIT = 4'd9;
   localparam logic [3:0] ST_OUT      = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.ring_read = 1'b1;
               state_in      = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.full) begin
               cmd.mul_load = 1'b1;
               cnt_in       = CNT_W'(MUL_STEPS - 1);
               state_in     = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DIFF;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.start = 1'b1;
            cnt_in    = CNT_W'(SQRT_STEPS - 1);
            state_in  = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_OFF_WAIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_OFF_WAIT: begin
            if (!sts.div_busy) begin
               cmd.off_capture = 1'b1;
               cmd.sig_start   = 1'b1;
               state_in        = ST_SIG_WAIT;
            end
         end
         ST_SIG_WAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = reset || (state_ff != ST_IDLE);

endmodule

`default_nettype wire

### hdl/sliding_window_sigma_and_offset_top.sv
// ============================================================================
// sliding_window_sigma_and_offset_top - moving window sigma and mean offset
// ----------------------------------------------------------------------------
// Keeps the last N samples with their running sum and sum of squares and,
// once the window is full, returns for every sample the population standard
// deviation and the distance of the window mean from a reference, both with
// eight fraction bits.
// ============================================================================
//
//   Channel  Direction  Handshake               Beat contents
//   req      in         req_valid / req_stall   req_sample
//   rsp      out        rsp_valid / rsp_stall   rsp_sigma, rsp_offset
//   csr      in         csr_wr_en               csr_index, csr_wr_data
//
// Let S = SAMPLE_BITS + clog2(MAX_WINDOW + 1), 30 at the default sizes.
// A sample that only fills the window passes the ring read, square, accumulate
// and check states. Once the window is full it then runs the shift-add
// multiplies of the S-bit running sum, then the bit-serial square root beside
// the offset division, then the sigma division, both on the one shared divider
// that produces a quotient bit per cycle.
// Reset is synchronous; it restores a window length of 10, a zero reference
// and an empty window. The ring needs no clearing pass: the fill count keeps
// every unwritten entry from being read.
// A stalled result waits in the output register; the next sample is accepted
// meanwhile and its processing stops just before the output stage.
// ============================================================================
`default_nettype none

module sliding_window_sigma_and_offset_top
   import sws_pkg::*;
#(
   parameter int MAX_WINDOW  = 32,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [SAMPLE_BITS-1:0]    req_sample,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [OUT_BITS-1:0]       rsp_sigma,
   output logic      [OUT_BITS-1:0]       rsp_offset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [SAMPLE_BITS-1:0]    csr_wr_data
);

   // Step counts of the bit-serial multiply and square root.
   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
   localparam int MUL_STEPS  = SUM_BITS;
   localparam int SQRT_STEPS = SUM_BITS + SIGMA_FRAC_BITS;

   sws_cmd_type cmd;
   sws_sts_type sts;

   // The controller only sequences; all arithmetic and storage is in the
   // datapath.
   sws_ctrl #(
      .MUL_STEPS  (MUL_STEPS),
      .SQRT_STEPS (SQRT_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sws_dp #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_sample  (req_sample),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sigma   (rsp_sigma),
      .rsp_offset  (rsp_offset)
   );

`ifndef SYNTHESIS
   // An accepted beat is squared in the very next cycle.
   a_accept_to_square: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.square)
      else $error("accepted sample was not processed in the next cycle");

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register overwritten while stalled");

   // The sigma division never restarts the shared divider in the middle of a division.
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      cmd.sig_start |-> !sts.div_busy)
      else $error("divider restarted while busy");

   // The statistics are only computed for a full window.
   a_full_before_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_load |-> sts.full)
      else $error("statistics started on a partly filled window");
`endif

endmodule

`default_nettype wire
